// ----- rtl/ikhm_pkg.sv -----
// Package for the integer key hash map: sizes, command codes and row layout.
// No dependencies.
`default_nettype none
package ikhm_pkg;
    localparam int BUCKETS = 256;
    localparam int WAYS = 4;
    localparam int BKT_W = $clog2(BUCKETS);
    localparam int CNT_W = 9;
    localparam int KEY_W = 31;
    localparam int VAL_W = 64;
    localparam int CMD_W = 2;
    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

    localparam logic [CMD_W-1:0] CMD_GET = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PUT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DEL = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } entry_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic found;
        logic [VAL_W-1:0] value_out;
        logic status;
    } rsp_t;
endpackage
`default_nettype wire

// ----- rtl/ikhm_if.sv -----
// Valid/ready channel interface carrying a payload of parameterized type.
// Depends on nothing.
`default_nettype none
interface ikhm_if #(parameter type payload_t = logic) (input wire logic clk);
    logic valid;
    logic ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/integer_key_hash_map.sv -----
// Integer key hash map: 256 buckets of 4 ways, key modulo bucket_count.
// After reset a pass over all 256 buckets clears the valid bits, with the input held off.
// One item at a time: a bit-serial modulo over the key bits, a memory read
// into a row register, a compare and write-back that registers the result, a
// hold register and the output register. The next item is taken once the
// result has moved to the output register, which waits while the output is
// held; the result sits in an output register while the next item is taken.
// Depends on ikhm_pkg, ikhm_if, ikhm_mod and ikhm_core.
`default_nettype none
module integer_key_hash_map
    import ikhm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    ikhm_if.sink      cfg,
    ikhm_if.sink      in,
    ikhm_if.source    out
);
    logic [CNT_W-1:0] cnt_reg;
    logic busy_reg;
    req_t req_reg;
    logic mod_done;
    logic [BKT_W-1:0] bucket;
    logic rsp_valid;
    rsp_t rsp;
    logic out_valid_reg;
    rsp_t out_reg;
    logic clr_busy;

    assign cfg.ready = 1'b1;
    assign in.ready = !busy_reg && !clr_busy;
    assign out.valid = out_valid_reg;
    assign out.data = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= CNT_W'(BUCKETS);
            busy_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
                cnt_reg <= cfg.data;
            if (in.valid && in.ready)
                busy_reg <= 1'b1;
            else if (rsp_valid && (!out_valid_reg || out.ready))
                busy_reg <= 1'b0;
            if (rsp_valid && (!out_valid_reg || out.ready))
                out_valid_reg <= 1'b1;
            else if (out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in.valid && in.ready)
            req_reg <= in.data;
        if (rsp_valid && (!out_valid_reg || out.ready))
            out_reg <= rsp;
    end

    ikhm_mod u_mod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (in.valid && in.ready),
        .key     (in.data.key),
        .divisor (cnt_reg),
        .done    (mod_done),
        .bucket  (bucket)
    );

    logic rsp_hold_reg;
    rsp_t rsp_hold;
    logic rsp_pend;
    ikhm_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (mod_done),
        .bucket    (bucket),
        .req       (req_reg),
        .clr_busy  (clr_busy),
        .rsp_valid (rsp_pend),
        .rsp       (rsp_hold)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_hold_reg <= 1'b0;
        else if (rsp_pend)
            rsp_hold_reg <= 1'b1;
        else if (!out_valid_reg || out.ready)
            rsp_hold_reg <= 1'b0;
    end

    assign rsp_valid = rsp_hold_reg;
    assign rsp = rsp_hold;
endmodule
`default_nettype wire

// ----- rtl/ikhm_mod.sv -----
// Bucket selection: key modulo bucket count, one quotient bit a cycle.
// Depends on ikhm_pkg.
`default_nettype none
module ikhm_mod
    import ikhm_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [KEY_W-1:0] key,
    input  wire logic [CNT_W-1:0] divisor,
    output logic                  done,
    output logic [BKT_W-1:0]      bucket
);
    localparam int STEP_W = $clog2(KEY_W + 1);
    logic [KEY_W-1:0]  key_reg;
    logic [CNT_W:0]    rem_reg;
    logic [CNT_W-1:0]  div_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic [CNT_W:0]    shifted;
    logic [CNT_W-1:0]  eff;

    always_comb
    begin
        eff = divisor;
        if (divisor == '0)
            eff = CNT_W'(1);
        else if (divisor > CNT_W'(BUCKETS))
            eff = CNT_W'(BUCKETS);
        shifted = {rem_reg[CNT_W-1:0], key_reg[KEY_W-1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            done     <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(KEY_W);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            key_reg <= key;
            rem_reg <= '0;
            div_reg <= eff;
        end
        else if (busy_reg)
        begin
            key_reg <= {key_reg[KEY_W-2:0], 1'b0};
            if (shifted >= {1'b0, div_reg})
                rem_reg <= shifted - {1'b0, div_reg};
            else
                rem_reg <= shifted;
        end
    end

    assign bucket = rem_reg[BKT_W-1:0];
endmodule
`default_nettype wire

// ----- rtl/ikhm_core.sv -----
// Bucket memory with valid bits, read-modify-write of one bucket row, and a pass clearing the valid bits after reset.
// Depends on ikhm_pkg.
`default_nettype none
module ikhm_core
    import ikhm_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             rd_en,
    input  wire logic [BKT_W-1:0] bucket,
    input  wire req_t             req,
    output logic                  clr_busy,
    output logic                  rsp_valid,
    output rsp_t                  rsp
);
    entry_t mem [BUCKETS][WAYS];
    logic [WAYS-1:0] vmem [BUCKETS];
    entry_t row_reg [WAYS];
    logic [WAYS-1:0] vrow_reg;
    logic [BKT_W-1:0] bkt_reg;
    logic cmp_reg;
    logic clr_busy_reg;
    logic [BKT_W-1:0] clr_addr_reg;

    logic hit, have_free;
    logic [WAY_W-1:0] hit_w, free_w;
    logic wr_en;
    logic [WAY_W-1:0] wr_w;
    entry_t wr_data;
    logic [WAYS-1:0] vnext;
    rsp_t rsp_next;

    always_comb
    begin
        hit = 1'b0;
        have_free = 1'b0;
        hit_w = '0;
        free_w = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (vrow_reg[w])
            begin
                if (!hit && row_reg[w].key == req.key)
                begin
                    hit = 1'b1;
                    hit_w = WAY_W'(w);
                end
            end
            else if (!have_free)
            begin
                have_free = 1'b1;
                free_w = WAY_W'(w);
            end
        end
        wr_en = 1'b0;
        wr_w = hit_w;
        wr_data.key = req.key;
        wr_data.value = req.value;
        vnext = vrow_reg;
        rsp_next.found = 1'b0;
        rsp_next.value_out = '0;
        rsp_next.status = 1'b0;
        unique case (req.cmd)
            CMD_GET:
            begin
                rsp_next.found = hit;
                if (hit)
                    rsp_next.value_out = row_reg[hit_w].value;
            end
            CMD_PUT:
            begin
                rsp_next.found = hit;
                if (hit)
                    wr_en = 1'b1;
                else if (have_free)
                begin
                    wr_en = 1'b1;
                    wr_w = free_w;
                    vnext[free_w] = 1'b1;
                end
                else
                    rsp_next.status = 1'b1;
            end
            CMD_DEL:
            begin
                rsp_next.found = hit;
                if (hit)
                    vnext[hit_w] = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            for (int w = 0; w < WAYS; w++)
                row_reg[w] <= mem[bucket][w];
            vrow_reg <= vmem[bucket];
            bkt_reg <= bucket;
        end
        if (cmp_reg && wr_en)
            mem[bkt_reg][wr_w] <= wr_data;
        if (clr_busy_reg)
            vmem[clr_addr_reg] <= '0;
        else if (cmp_reg)
            vmem[bkt_reg] <= vnext;
        if (cmp_reg)
            rsp <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
            cmp_reg      <= 1'b0;
            rsp_valid    <= 1'b0;
        end
        else
        begin
            cmp_reg   <= rd_en;
            rsp_valid <= cmp_reg;
            if (clr_busy_reg)
            begin
                clr_addr_reg <= clr_addr_reg + BKT_W'(1);
                if (clr_addr_reg == BKT_W'(BUCKETS - 1))
                    clr_busy_reg <= 1'b0;
            end
        end
    end

    assign clr_busy = clr_busy_reg;
endmodule
`default_nettype wire

// ----- rtl/ikhm_checker.sv -----
// Port-level checks for integer_key_hash_map, bound to the top level.
// Depends on ikhm_pkg and integer_key_hash_map.
`default_nettype none
module ikhm_checker
    import ikhm_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire rsp_t out_data
);
    a_refused_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status |-> !out_data.found) else $error("status with found");
    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status |-> out_data.value_out == '0) else $error("status value");
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready) else $error("second transfer");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("out dropped");
endmodule

bind integer_key_hash_map ikhm_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in.valid),
    .in_ready  (in.ready),
    .out_valid (out.valid),
    .out_ready (out.ready),
    .out_data  (out.data)
);
`default_nettype wire

// ----- verif/integer_key_hash_map_tb.sv -----
// Testbench for integer_key_hash_map: directed and random get/put/delete/nop traffic
// checked against an in-bench model of the bucketed table and its bucket_count.
// Depends on ikhm_pkg, ikhm_if and the integer_key_hash_map RTL.
module integer_key_hash_map_tb;
    import ikhm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [CNT_W-1:0] cnt_t;

    logic clk;
    logic rst_n;

    ikhm_if #(.payload_t(cnt_t)) cfg_ch (clk);
    ikhm_if #(.payload_t(req_t)) req_ch (clk);
    ikhm_if #(.payload_t(rsp_t)) rsp_ch (clk);

    integer_key_hash_map dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch.sink),
        .in    (req_ch.sink),
        .out   (rsp_ch.source)
    );

    bit               tbl_valid [BUCKETS*WAYS];
    logic [KEY_W-1:0] tbl_key   [BUCKETS*WAYS];
    logic [VAL_W-1:0] tbl_val   [BUCKETS*WAYS];
    int unsigned      buckets_in_use;

    rsp_t        pending_rsps[$];
    int unsigned mismatches;
    int unsigned rsp_count;
    int unsigned req_count;
    int unsigned cfg_count;
    bit          src_idle_on;
    bit          snk_idle_on;
    bit          hold_off;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #100ms;
        $display("Regression FAIL");
        $finish;
    end

    function automatic rsp_t apply_op(req_t r);
        rsp_t        res;
        int unsigned n;
        int unsigned base;
        bit          hit;
        bit          have_free;
        int unsigned hit_i;
        int unsigned free_i;
        res = '0;
        hit = 1'b0;
        have_free = 1'b0;
        hit_i = 0;
        free_i = 0;
        n = (buckets_in_use == 0) ? 1 : buckets_in_use;
        if (n > BUCKETS)
            n = BUCKETS;
        base = (r.key % n) * WAYS;
        for (int w = 0; w < WAYS; w++)
        begin
            if (tbl_valid[base+w])
            begin
                if (!hit && tbl_key[base+w] == r.key)
                begin
                    hit = 1'b1;
                    hit_i = base + w;
                end
            end
            else if (!have_free)
            begin
                have_free = 1'b1;
                free_i = base + w;
            end
        end
        if (r.cmd == CMD_GET)
        begin
            if (hit)
            begin
                res.found = 1'b1;
                res.value_out = tbl_val[hit_i];
            end
        end
        else if (r.cmd == CMD_PUT)
        begin
            if (hit)
            begin
                res.found = 1'b1;
                tbl_val[hit_i] = r.value;
            end
            else if (have_free)
            begin
                tbl_valid[free_i] = 1'b1;
                tbl_key[free_i] = r.key;
                tbl_val[free_i] = r.value;
            end
            else
                res.status = 1'b1;
        end
        else if (r.cmd == CMD_DEL)
        begin
            if (hit)
            begin
                res.found = 1'b1;
                tbl_valid[hit_i] = 1'b0;
            end
        end
        return res;
    endfunction

    // valid stays high after a transfer; drop it only before a gap
    task automatic send_op(logic [CMD_W-1:0] c, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
        req_t r;
        if (src_idle_on && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        r.cmd = c;
        r.key = k;
        r.value = v;
        req_ch.valid <= 1'b1;
        req_ch.data <= r;
        do
            @(posedge clk);
        while (!req_ch.ready);
        pending_rsps.push_back(apply_op(r));
        req_count++;
    endtask

    task automatic drain();
        int unsigned guard;
        guard = 0;
        req_ch.valid <= 1'b0;
        while (pending_rsps.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        if (guard >= 200000)
        begin
            $display("Regression FAIL");
            $finish;
        end
        repeat (80) @(posedge clk);
    endtask

    task automatic write_bucket_count(cnt_t n);
        drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= n;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        buckets_in_use = n;
        cfg_count++;
    endtask

    function automatic logic [VAL_W-1:0] rand_value();
        return {$urandom(), $urandom()};
    endfunction

    // keys come mostly from a small range so that buckets fill and hits are common
    function automatic logic [KEY_W-1:0] rand_key(int unsigned span);
        if ($urandom_range(0, 9) == 0)
            return KEY_W'($urandom());
        return KEY_W'($urandom_range(0, span));
    endfunction

    task automatic test_directed();
        logic [KEY_W-1:0] kmax;
        kmax = '1;
        send_op(CMD_GET, '0, '0);
        send_op(CMD_PUT, '0, '1);
        send_op(CMD_GET, '0, '0);
        send_op(CMD_PUT, kmax, 64'h8000_0000_0000_0001);
        send_op(CMD_GET, kmax, '1);
        send_op(CMD_PUT, kmax, 64'h5555_aaaa_5555_aaaa);
        send_op(CMD_GET, kmax, '0);
        send_op(CMD_DEL, kmax, '0);
        send_op(CMD_GET, kmax, '0);
        send_op(CMD_DEL, kmax, '0);
        for (int i = 1; i <= 5; i++)
            send_op(CMD_PUT, KEY_W'(i * 256), rand_value());
        send_op(CMD_GET, KEY_W'(5 * 256), '0);
        send_op(CMD_DEL, KEY_W'(2 * 256), '0);
        send_op(CMD_PUT, KEY_W'(5 * 256), 64'h1234);
        send_op(CMD_GET, KEY_W'(5 * 256), '0);
        send_op(CMD_NOP, KEY_W'(256), '1);
        send_op(CMD_GET, KEY_W'(256), '0);
    endtask

    task automatic test_bucket_count_change();
        write_bucket_count(9'd1);
        for (int i = 0; i < 6; i++)
            send_op(CMD_PUT, KEY_W'($urandom()), rand_value());
        send_op(CMD_GET, '0, '0);
        write_bucket_count(9'd3);
        send_op(CMD_GET, KEY_W'(256), '0);
        send_op(CMD_GET, KEY_W'(512), '0);
        write_bucket_count(9'd0);
        send_op(CMD_PUT, KEY_W'(7), rand_value());
        send_op(CMD_GET, KEY_W'(7), '0);
        write_bucket_count(9'd511);
        send_op(CMD_GET, KEY_W'(7), '0);
        send_op(CMD_GET, KEY_W'(256), '0);
    endtask

    task automatic run_random(int unsigned count, int unsigned span);
        logic [CMD_W-1:0] c;
        int unsigned      pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
                c = CMD_GET;
            else if (pick < 75)
                c = CMD_PUT;
            else if (pick < 97)
                c = CMD_DEL;
            else
                c = CMD_NOP;
            send_op(c, rand_key(span), rand_value());
        end
    endtask

    task automatic test_random_settings();
        cnt_t settings[6];
        settings = '{9'd256, 9'd1, 9'd2, 9'd17, 9'd255, 9'd100};
        foreach (settings[s])
        begin
            write_bucket_count(settings[s]);
            run_random(260, 3000);
        end
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        run_random(20, 600);
        hold_off = 1'b0;
    endtask

    task automatic test_full_rate();
        drain();
        src_idle_on = 1'b0;
        snk_idle_on = 1'b0;
        run_random(300, 1200);
    endtask

    // sink: random ready, long hold-off on request
    initial
    begin
        int unsigned held;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off)
            begin
                held = 0;
                rsp_ch.ready <= 1'b0;
                while (held < 400)
                begin
                    @(posedge clk);
                    held++;
                end
                rsp_ch.ready <= 1'b1;
                @(posedge clk);
            end
            else if (snk_idle_on && $urandom_range(0, 5) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial
    begin
        rsp_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                rsp_count++;
                if (pending_rsps.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected transfer: found=%0b value=%h status=%0b",
                                 rsp_ch.data.found, rsp_ch.data.value_out,
                                 rsp_ch.data.status);
                end
                else
                begin
                    want = pending_rsps.pop_front();
                    if (rsp_ch.data.found !== want.found
                        || rsp_ch.data.value_out !== want.value_out
                        || rsp_ch.data.status !== want.status)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch #%0d: exp found=%0b value=%h status=%0b,",
                                      " got found=%0b value=%h status=%0b"},
                                     rsp_count, want.found, want.value_out, want.status,
                                     rsp_ch.data.found, rsp_ch.data.value_out,
                                     rsp_ch.data.status);
                    end
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        buckets_in_use = BUCKETS;
        mismatches = 0;
        rsp_count = 0;
        req_count = 0;
        cfg_count = 0;
        src_idle_on = 1'b1;
        snk_idle_on = 1'b1;
        hold_off = 1'b0;
        foreach (tbl_valid[i])
        begin
            tbl_valid[i] = 1'b0;
            tbl_key[i] = '0;
            tbl_val[i] = '0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_bucket_count_change();
        test_random_settings();
        test_backpressure();
        test_full_rate();
        drain();
        if (pending_rsps.size() != 0)
            mismatches++;
        $display("Covered %0d operations and %0d bucket_count writes (1, 0, 511, 256 and others),",
                 req_count, cfg_count);
        $display("%0d results checked, with random gaps, a long hold-off and a full-rate stretch.",
                 rsp_count);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

// ----- files.f -----
rtl/ikhm_pkg.sv
rtl/ikhm_if.sv
rtl/ikhm_mod.sv
rtl/ikhm_core.sv
rtl/integer_key_hash_map.sv
rtl/ikhm_checker.sv
verif/integer_key_hash_map_tb.sv
